### hw/rtl/aripd_pkg.sv
// ----------------------------------------------------------------------------
// aripd_pkg
// Shared types and constants for the AT response / +IPD parser.
// ----------------------------------------------------------------------------
`default_nettype none

package aripd_pkg;

    // Input word: one request per handshake
    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] rx_byte;
    } t_in_word;

    // Result word: one per accepted input word
    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [3:0] payload_link;
        logic       payload_last;
        logic [2:0] cmd_status;
        logic [2:0] line_event;
    } t_out_word;

    // Request codes
    localparam logic [1:0] REQ_BYTE = 2'd0;
    localparam logic [1:0] REQ_CMD  = 2'd1;
    localparam logic [1:0] REQ_SEND = 2'd2;

    // Parser modes
    typedef enum logic [1:0] {
        MODE_LINE    = 2'd0,
        MODE_LEN     = 2'd1,
        MODE_PAYLOAD = 2'd2
    } t_parse_mode;

    // Command tracking
    typedef enum logic [2:0] {
        CMD_IDLE    = 3'd0,
        CMD_PENDING = 3'd1,
        CMD_SENDING = 3'd2,
        CMD_SUCCESS = 3'd3,
        CMD_ERROR   = 3'd4
    } t_cmd_state;

    // Line event codes
    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_OK     = 3'd1,
        EV_ERROR  = 3'd2,
        EV_GOTIP  = 3'd3,
        EV_PROMPT = 3'd4
    } t_line_event;

    // Keyword hit flags at the newest byte
    typedef struct packed {
        logic ok;
        logic error;
        logic gotip;
        logic fail;
    } t_kw_hits;

    // Line head: first bytes of a line, index 0 is the first byte
    localparam int HEAD_KEEP  = 10;
    localparam int HEAD_IDX_W = 4;
    typedef logic [HEAD_KEEP-1:0][7:0] t_head;

    // Tail window: 10 stored bytes plus the incoming byte
    localparam int TAIL_KEEP = 10;
    typedef logic [TAIL_KEEP*8-1:0]     t_tail;
    typedef logic [(TAIL_KEEP+1)*8-1:0] t_window;

    // Header field positions
    localparam logic [HEAD_IDX_W-1:0] POS_LINK  = 4'd7;
    localparam logic [HEAD_IDX_W-1:0] POS_DIGIT = 4'd9;

    // Single characters
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_GT    = ">";
    localparam logic [7:0] CHAR_COLON = ":";
    localparam logic [7:0] CHAR_ZERO  = "0";
    localparam logic [7:0] ASCII_MAX  = 8'h7F;

    // Match strings, last character in the low byte
    localparam logic [31:0] KW_OK    = {"OK", CHAR_CR, CHAR_LF};
    localparam logic [55:0] KW_ERROR = {"ERROR", CHAR_CR, CHAR_LF};
    localparam logic [87:0] KW_GOTIP = "WIFI GOT IP";
    localparam logic [47:0] KW_FAIL  = {"FAIL", CHAR_CR, CHAR_LF};
    localparam logic [55:0] IPD_HDR  = {CHAR_CR, CHAR_LF, "+IPD,"};

    // Link mask after reset
    localparam logic [3:0] LINK_MASK_RST = 4'd7;

endpackage

`default_nettype wire

### hw/rtl/aripd_in_reg.sv
// ----------------------------------------------------------------------------
// aripd_in_reg
// Input register stage; holds one word and stalls upstream only when full
// and the core cannot take the word this cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module aripd_in_reg (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire aripd_pkg::t_in_word i_in_data,
    output logic                    o_in_stall,
    output logic                    o_vld,
    output aripd_pkg::t_in_word     o_word,
    input  wire logic               i_take
);

    logic                r_vld;
    aripd_pkg::t_in_word r_word;

    // full and not draining this cycle
    assign o_in_stall = r_vld && !i_take;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_vld <= i_in_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_word <= i_in_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_word = r_word;

endmodule

`default_nettype wire

### hw/rtl/aripd_line_scan.sv
// ----------------------------------------------------------------------------
// aripd_line_scan
// Fixed-position compares: keyword endings in the tail window and the
// +IPD header at the start of the line.
// ----------------------------------------------------------------------------
`default_nettype none

module aripd_line_scan (
    input  wire aripd_pkg::t_window i_window,
    input  wire aripd_pkg::t_head   i_head,
    output aripd_pkg::t_kw_hits     o_hits,
    output logic                    o_ipd_hdr
);

    // keyword ends at the newest byte (low byte of the window)
    assign o_hits.ok    = (i_window[31:0] == aripd_pkg::KW_OK);
    assign o_hits.error = (i_window[55:0] == aripd_pkg::KW_ERROR);
    assign o_hits.gotip = (i_window[87:0] == aripd_pkg::KW_GOTIP);
    assign o_hits.fail  = (i_window[47:0] == aripd_pkg::KW_FAIL);

    // header bytes 0..6
    assign o_ipd_hdr = ({i_head[0], i_head[1], i_head[2], i_head[3],
                         i_head[4], i_head[5], i_head[6]} == aripd_pkg::IPD_HDR);

endmodule

`default_nettype wire

### hw/rtl/aripd_core.sv
// ----------------------------------------------------------------------------
// aripd_core
// Parser state, single-pass next-state logic and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module aripd_core #(
    parameter int LINE_MAX  = 256,
    parameter int LINK_BITS = 4
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [3:0]          i_link_mask,
    input  wire logic                i_vld,
    input  wire aripd_pkg::t_in_word i_word,
    output logic                     o_take,
    output logic                     o_out_valid,
    output aripd_pkg::t_out_word     o_out_data,
    input  wire logic                i_out_stall
);

    localparam int CNT_W = $clog2(LINE_MAX + 1);

    localparam logic [aripd_pkg::HEAD_IDX_W-1:0] POS_LINK_IDX  = aripd_pkg::POS_LINK;
    localparam logic [aripd_pkg::HEAD_IDX_W-1:0] POS_DIGIT_IDX = aripd_pkg::POS_DIGIT;

    // length digit: (b - '0') kept to 16 bits
    function automatic logic [15:0] digit16(input logic [7:0] b);
        digit16 = {8'd0, b} - {8'd0, aripd_pkg::CHAR_ZERO};
    endfunction

    // x*10 + digit, wrapping at 16 bits
    function automatic logic [15:0] fold(input logic [15:0] x, input logic [7:0] b);
        fold = (x << 3) + (x << 1) + digit16(b);
    endfunction

    // state
    aripd_pkg::t_parse_mode r_mode, n_mode;
    logic [CNT_W-1:0]       r_count, n_count;
    aripd_pkg::t_tail       r_tail, n_tail;
    aripd_pkg::t_kw_hits    r_kw, n_kw;
    logic [LINK_BITS-1:0]   r_link, n_link;
    logic [15:0]            r_left, n_left;
    aripd_pkg::t_cmd_state  r_cmd, n_cmd;
    logic                   r_drop, n_drop;
    aripd_pkg::t_head       r_head;
    logic                   head_we;

    // result register
    logic                   r_out_vld;
    aripd_pkg::t_out_word   r_out, n_out;

    aripd_pkg::t_window     window;
    aripd_pkg::t_kw_hits    hits;
    logic                   ipd_hdr;

    assign o_take = i_vld && (!r_out_vld || !i_out_stall);
    assign window = {r_tail, i_word.rx_byte};

    aripd_line_scan u_scan (
        .i_window  (window),
        .i_head    (r_head),
        .o_hits    (hits),
        .o_ipd_hdr (ipd_hdr)
    );

    // next state and result
    always_comb begin
        logic [7:0]            b;
        logic                  done;
        logic                  clr;
        aripd_pkg::t_kw_hits   kw_now;
        aripd_pkg::t_cmd_state result;
        aripd_pkg::t_line_event ev;
        logic [15:0]           base;
        logic [15:0]           dlink;

        b       = i_word.rx_byte;
        done    = 1'b0;
        clr     = 1'b0;
        kw_now  = r_kw | hits;
        result  = aripd_pkg::CMD_IDLE;
        ev      = aripd_pkg::EV_NONE;
        base    = digit16(r_head[POS_DIGIT_IDX]);
        dlink   = digit16(r_head[POS_LINK_IDX]);
        head_we = 1'b0;

        n_mode = r_mode;
        n_count = r_count;
        n_tail = r_tail;
        n_kw   = r_kw;
        n_link = r_link;
        n_left = r_left;
        n_cmd  = r_cmd;
        n_drop = r_drop;
        n_out  = '0;

        case (i_word.req_type)
            aripd_pkg::REQ_CMD: begin
                n_cmd = aripd_pkg::CMD_PENDING;
            end
            aripd_pkg::REQ_SEND: begin
                n_cmd = aripd_pkg::CMD_SENDING;
            end
            aripd_pkg::REQ_BYTE: begin
                if (r_drop) begin
                    n_drop = 1'b0;
                end else begin
                    case (r_mode)
                        aripd_pkg::MODE_LEN: begin
                            if (b == aripd_pkg::CHAR_COLON) begin
                                n_mode = (r_left == 16'd0) ? aripd_pkg::MODE_LINE
                                                           : aripd_pkg::MODE_PAYLOAD;
                            end else begin
                                n_left = fold(r_left, b);
                            end
                        end
                        aripd_pkg::MODE_PAYLOAD: begin
                            n_out.payload_valid = 1'b1;
                            n_out.payload_byte  = b;
                            n_out.payload_link  = 4'(r_link);
                            if (r_left <= 16'd1) begin
                                n_left              = 16'd0;
                                n_out.payload_last  = 1'b1;
                                n_mode              = aripd_pkg::MODE_LINE;
                            end else begin
                                n_left = r_left - 16'd1;
                            end
                        end
                        default: begin
                            // line mode
                            head_we = (r_count < CNT_W'(aripd_pkg::HEAD_KEEP));
                            n_tail  = window[aripd_pkg::TAIL_KEEP*8-1:0];
                            n_kw    = kw_now;
                            if (b > aripd_pkg::ASCII_MAX) begin
                                // non-ASCII byte only extends the line
                            end else if (b == aripd_pkg::CHAR_LF && r_count > CNT_W'(2)) begin
                                if (kw_now.ok) begin
                                    ev = aripd_pkg::EV_OK;
                                    result = aripd_pkg::CMD_SUCCESS;
                                end else if (kw_now.error) begin
                                    ev = aripd_pkg::EV_ERROR;
                                    result = aripd_pkg::CMD_ERROR;
                                end else if (kw_now.gotip) begin
                                    ev = aripd_pkg::EV_GOTIP;
                                end else if (kw_now.fail) begin
                                    ev = aripd_pkg::EV_ERROR;
                                    result = aripd_pkg::CMD_ERROR;
                                end
                                if (result != aripd_pkg::CMD_IDLE &&
                                    (r_cmd inside {aripd_pkg::CMD_PENDING,
                                                   aripd_pkg::CMD_SENDING})) begin
                                    n_cmd = result;
                                end
                                if (ev != aripd_pkg::EV_NONE) begin
                                    clr  = 1'b1;
                                    done = 1'b1;
                                end
                            end else if (r_cmd == aripd_pkg::CMD_SENDING) begin
                                if (b == aripd_pkg::CHAR_GT) begin
                                    n_cmd  = aripd_pkg::CMD_SUCCESS;
                                    n_drop = 1'b1;
                                    ev     = aripd_pkg::EV_PROMPT;
                                    clr    = 1'b1;
                                    done   = 1'b1;
                                end
                            end else if (r_count == CNT_W'(aripd_pkg::HEAD_KEEP) &&
                                         ipd_hdr) begin
                                n_link = dlink[LINK_BITS-1:0] & i_link_mask[LINK_BITS-1:0];
                                if (b == aripd_pkg::CHAR_COLON) begin
                                    n_left = base;
                                    n_mode = (base == 16'd0) ? aripd_pkg::MODE_LINE
                                                             : aripd_pkg::MODE_PAYLOAD;
                                end else begin
                                    n_left = fold(base, b);
                                    n_mode = aripd_pkg::MODE_LEN;
                                end
                                clr  = 1'b1;
                                done = 1'b1;
                            end
                            if (clr) begin
                                n_count = '0;
                                n_kw    = '0;
                                n_tail  = '0;
                            end else if (!done && r_count < CNT_W'(LINE_MAX)) begin
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                    endcase
                end
            end
            default: begin
                // unused request code: status only
            end
        endcase

        n_out.cmd_status = r_cmd == n_cmd ? r_cmd : n_cmd;
        n_out.line_event = ev;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= aripd_pkg::MODE_LINE;
            r_count <= '0;
            r_tail  <= '0;
            r_kw    <= '0;
            r_link  <= '0;
            r_left  <= 16'd0;
            r_cmd   <= aripd_pkg::CMD_IDLE;
            r_drop  <= 1'b0;
        end else if (o_take) begin
            r_mode  <= n_mode;
            r_count <= n_count;
            r_tail  <= n_tail;
            r_kw    <= n_kw;
            r_link  <= n_link;
            r_left  <= n_left;
            r_cmd   <= n_cmd;
            r_drop  <= n_drop;
        end
    end

    // line head capture, no reset
    always_ff @(posedge i_clk) begin
        if (o_take && head_we) begin
            r_head[r_count[aripd_pkg::HEAD_IDX_W-1:0]] <= i_word.rx_byte;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (!r_out_vld || !i_out_stall) begin
            r_out_vld <= o_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

### hw/rtl/at_response_ipd_parser_top.sv
// An accepted input word goes through the input register, then the result
// register. Throughput: one word per cycle while i_out_stall is low; the two
// registers decouple the sides, so one word is taken while a result waits.
// Reset (i_rst_n low, synchronous): line mode, counters, tail window,
// command status and link mask (back to 7) cleared; line head is not reset.
// ----------------------------------------------------------------------------
// at_response_ipd_parser_top
// AT response parser with +IPD packet extraction: completes commands on
// OK / ERROR / FAIL lines and forwards packet payload tagged with its link.
// ----------------------------------------------------------------------------
`default_nettype none

module at_response_ipd_parser_top #(
    parameter int LINE_MAX  = 256,
    parameter int LINK_BITS = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // input words
    input  wire logic                 i_in_valid,
    input  wire aripd_pkg::t_in_word  i_in_data,
    output logic                      o_in_stall,
    // result words
    output logic                      o_out_valid,
    output aripd_pkg::t_out_word      o_out_data,
    input  wire logic                 i_out_stall,
    // link mask register
    input  wire logic                 i_cfg_valid,
    input  wire logic [3:0]           i_cfg_data,
    output logic                      o_cfg_ready
);

    logic                cfg_write;
    logic [3:0]          r_mask;
    logic                st_vld;
    aripd_pkg::t_in_word st_word;
    logic                take;

    // link mask register, always ready
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= aripd_pkg::LINK_MASK_RST;
        end else if (cfg_write) begin
            r_mask <= i_cfg_data;
        end
    end

    aripd_in_reg u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .o_vld      (st_vld),
        .o_word     (st_word),
        .i_take     (take)
    );

    aripd_core #(
        .LINE_MAX  (LINE_MAX),
        .LINK_BITS (LINK_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_link_mask (r_mask),
        .i_vld       (st_vld),
        .i_word      (st_word),
        .o_take      (take),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire
